FILE: hdl/pll_divider_search_unit_assert.svh
// -----------------------------------------------------------------------------
// PLL divider search assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the synchronous active-low reset is asserted.
// -----------------------------------------------------------------------------
`ifndef PLL_DIVIDER_SEARCH_UNIT_ASSERT_SVH
`define PLL_DIVIDER_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define PDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pds_pkg.sv
// -----------------------------------------------------------------------------
// PLL divider search package
// Shared widths, register index codes, reset values and interface structs.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pds_pkg;

    localparam int PDS_QW       = 24;
    localparam int PDS_REQ_W    = 21;
    localparam int PDS_REF_W    = 16;
    localparam int PDS_FB_OUT_W = 9;
    localparam int PDS_PD_OUT_W = 3;
    localparam int PDS_IDX_W    = 2;

    // divider: bits retired per cycle and cycles per quotient
    localparam int PDS_DIV_STEP = 8;
    localparam int PDS_DIV_CYC  = PDS_QW / PDS_DIV_STEP;
    localparam int PDS_DIV_CW   = $clog2(PDS_DIV_CYC);

    localparam logic [PDS_IDX_W-1:0] REG_REF_KHZ     = 2'd0;
    localparam logic [PDS_IDX_W-1:0] REG_VCO_MIN_KHZ = 2'd1;
    localparam logic [PDS_IDX_W-1:0] REG_VCO_MAX_KHZ = 2'd2;
    localparam logic [PDS_IDX_W-1:0] REG_PREFER_LOW  = 2'd3;

    localparam logic [PDS_REF_W-1:0] RST_REF_KHZ     = 16'd12000;
    localparam logic [PDS_QW-1:0]    RST_VCO_MIN_KHZ = 24'd400000;
    localparam logic [PDS_QW-1:0]    RST_VCO_MAX_KHZ = 24'd1600000;

    typedef struct packed {
        logic [PDS_REF_W-1:0] ref_khz;
        logic [PDS_QW-1:0]    vco_min_khz;
        logic [PDS_QW-1:0]    vco_max_khz;
        logic                 prefer_low_vco;
    } t_cfg;

    typedef struct packed {
        logic              done;
        logic              rem_zero;
        logic [PDS_QW-1:0] quo;
    } t_div_res;

endpackage

FILE: hdl/pds_cfg.sv
// -----------------------------------------------------------------------------
// PLL divider search configuration registers
// Write-only register bank holding reference, VCO window and search order.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pds_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pds_pkg::PDS_IDX_W-1:0] i_cfg_idx,
    input  logic [pds_pkg::PDS_QW-1:0]    i_cfg_wdata,
    output pds_pkg::t_cfg                 o_cfg
);

    pds_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_khz        <= pds_pkg::RST_REF_KHZ;
            r_cfg.vco_min_khz    <= pds_pkg::RST_VCO_MIN_KHZ;
            r_cfg.vco_max_khz    <= pds_pkg::RST_VCO_MAX_KHZ;
            r_cfg.prefer_low_vco <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pds_pkg::REG_REF_KHZ: begin
                    r_cfg.ref_khz <= i_cfg_wdata[pds_pkg::PDS_REF_W-1:0];
                end
                pds_pkg::REG_VCO_MIN_KHZ: begin
                    r_cfg.vco_min_khz <= i_cfg_wdata;
                end
                pds_pkg::REG_VCO_MAX_KHZ: begin
                    r_cfg.vco_max_khz <= i_cfg_wdata;
                end
                pds_pkg::REG_PREFER_LOW: begin
                    r_cfg.prefer_low_vco <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/pds_div.sv
// -----------------------------------------------------------------------------
// PLL divider search iterative divider
// Restoring divider, several quotient bits per cycle; VCO by post-divider product.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pds_div #(
    parameter int DW = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pds_pkg::PDS_QW-1:0] i_dividend,
    input  logic [DW-1:0]              i_divisor,
    output pds_pkg::t_div_res          o_res
);

    logic                           r_busy;
    logic                           r_done;
    logic [pds_pkg::PDS_DIV_CW-1:0] r_cnt;
    logic [pds_pkg::PDS_QW-1:0]     r_quo;
    logic [DW-1:0]                  r_rem;
    logic [DW-1:0]                  r_den;
    logic [pds_pkg::PDS_QW-1:0]     n_quo;
    logic [DW-1:0]                  n_rem;

    always_comb begin
        logic [DW:0]                t;
        logic [DW-1:0]              rem;
        logic [pds_pkg::PDS_QW-1:0] quo;
        rem = r_rem;
        quo = r_quo;
        for (int k = 0; k < pds_pkg::PDS_DIV_STEP; k++) begin
            t   = {rem, quo[pds_pkg::PDS_QW-1]};
            quo = {quo[pds_pkg::PDS_QW-2:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                t      = t - {1'b0, r_den};
                quo[0] = 1'b1;
            end
            rem = t[DW-1:0];
        end
        n_quo = quo;
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pds_pkg::PDS_DIV_CW'(pds_pkg::PDS_DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_res.done     = r_done;
    assign o_res.rem_zero = (r_rem == '0);
    assign o_res.quo      = r_quo;

endmodule

FILE: hdl/pll_divider_search_unit.sv
// -----------------------------------------------------------------------------
// PLL divider search unit
// Searches feedback and post dividers for the output closest to a request.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one requested frequency.
//   Output channel (o_out_valid / i_out_ready) returns one result transaction:
//   found and exact flags, achieved output, VCO and the three divider values.
//   Settings are all zero when no candidate beats the error bound.
//   One request is searched at a time; o_in_ready is high only while idle.
//   Steps: multiply, window check and step for each feedback divider, and
//   for each post-divider pair on a divider whose VCO is in the window,
//   start, divider wait and compare. The 8-bit-per-cycle single divider
//   sets the per-pair cost.
//   A finished result sits in the output register; a new request is taken
//   while it waits. A second result waits in the last state until the
//   receiver takes the first. Reset (synchronous, active low) restores
//   register defaults and drops any search and any pending result. The user
//   must write configuration only while idle; the block does not enforce it.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pll_divider_search_unit_assert.svh"

module pll_divider_search_unit #(
    parameter int FB_DIV_MIN      = 16,
    parameter int FB_DIV_MAX      = 320,
    parameter int POST_DIV_MAX    = 7,
    parameter int ERROR_BOUND_KHZ = 100000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pds_pkg::PDS_IDX_W-1:0]       i_cfg_idx,
    input  logic [pds_pkg::PDS_QW-1:0]          i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pds_pkg::PDS_REQ_W-1:0]       i_req_khz,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic                                o_exact,
    output logic [pds_pkg::PDS_QW-1:0]          o_out_khz,
    output logic [pds_pkg::PDS_QW-1:0]          o_vco_khz,
    output logic [pds_pkg::PDS_FB_OUT_W-1:0]    o_feedback_div,
    output logic [pds_pkg::PDS_PD_OUT_W-1:0]    o_post_div_one,
    output logic [pds_pkg::PDS_PD_OUT_W-1:0]    o_post_div_two
);

    localparam int FB_W = $clog2(FB_DIV_MAX + 1);
    localparam int PD_W = $clog2(POST_DIV_MAX + 1);
    localparam int DV_W = 2 * PD_W;
    localparam int VW   = FB_W + pds_pkg::PDS_REF_W;
    localparam int CW   = (VW > pds_pkg::PDS_QW) ? VW : pds_pkg::PDS_QW;
    localparam int QW   = pds_pkg::PDS_QW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_CHK    = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DWAIT  = 3'd4;
    localparam logic [2:0] S_EVAL   = 3'd5;
    localparam logic [2:0] S_NEXT   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    pds_pkg::t_cfg     cfg;
    pds_pkg::t_div_res div_res;

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    logic [pds_pkg::PDS_REQ_W-1:0]  r_req;
    logic [FB_W-1:0]                r_fb;
    logic [PD_W-1:0]                r_p1;
    logic [PD_W-1:0]                r_p2;
    logic [CW-1:0]                  r_vco;
    logic [QW-1:0]                  r_best_err;
    logic                           r_found;
    logic                           r_b_rz;
    logic [QW-1:0]                  r_b_khz;
    logic [QW-1:0]                  r_b_vco;
    logic [FB_W-1:0]                r_b_fb;
    logic [PD_W-1:0]                r_b_p1;
    logic [PD_W-1:0]                r_b_p2;
    logic                           r_out_valid;
    logic                           r_o_found;
    logic                           r_o_exact;
    logic [QW-1:0]                  r_o_khz;
    logic [QW-1:0]                  r_o_vco;
    logic [FB_W-1:0]                r_o_fb;
    logic [PD_W-1:0]                r_o_p1;
    logic [PD_W-1:0]                r_o_p2;

    logic                           in_acc;
    logic                           out_load;
    logic [FB_W-1:0]                fb_first;
    logic [FB_W-1:0]                fb_last;
    logic [VW-1:0]                  vco_prod;
    logic                           in_win;
    logic [DV_W-1:0]                div_den;
    logic [QW-1:0]                  req_ext;
    logic [QW-1:0]                  err;
    logic                           better;
    logic                           last_pair;

    pds_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pds_div #(
        .DW (DV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_dividend (r_vco[QW-1:0]),
        .i_divisor  (div_den),
        .o_res      (div_res)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign fb_first  = cfg.prefer_low_vco ? FB_W'(FB_DIV_MIN) : FB_W'(FB_DIV_MAX);
    assign fb_last   = cfg.prefer_low_vco ? FB_W'(FB_DIV_MAX) : FB_W'(FB_DIV_MIN);
    assign vco_prod  = VW'(r_fb) * VW'(cfg.ref_khz);
    assign in_win    = (r_vco >= CW'(cfg.vco_min_khz)) && (r_vco <= CW'(cfg.vco_max_khz));
    assign div_den   = DV_W'(r_p1) * DV_W'(r_p2);
    assign req_ext   = QW'(r_req);
    assign err       = (div_res.quo > req_ext) ? (div_res.quo - req_ext)
                                               : (req_ext - div_res.quo);
    assign better    = (err < r_best_err);
    assign last_pair = (r_p1 == PD_W'(1)) && (r_p2 == PD_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_acc) n_state = S_MUL;
            S_MUL:    n_state = S_CHK;
            S_CHK:    n_state = in_win ? S_DSTART : S_NEXT;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT:  if (div_res.done) n_state = S_EVAL;
            S_EVAL:   n_state = last_pair ? S_NEXT : S_DSTART;
            S_NEXT:   n_state = (r_fb == fb_last) ? S_DONE : S_MUL;
            S_DONE:   if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req      <= i_req_khz;
            r_fb       <= fb_first;
            r_best_err <= QW'(ERROR_BOUND_KHZ);
            r_found    <= 1'b0;
            r_b_rz     <= 1'b0;
            r_b_khz    <= '0;
            r_b_vco    <= '0;
            r_b_fb     <= '0;
            r_b_p1     <= '0;
            r_b_p2     <= '0;
        end
        if (r_state == S_MUL) begin
            r_vco <= CW'(vco_prod);
        end
        if (r_state == S_CHK) begin
            r_p1 <= PD_W'(POST_DIV_MAX);
            r_p2 <= PD_W'(POST_DIV_MAX);
        end
        if (r_state == S_EVAL) begin
            if (better) begin
                r_best_err <= err;
                r_found    <= 1'b1;
                r_b_rz     <= div_res.rem_zero;
                r_b_khz    <= div_res.quo;
                r_b_vco    <= r_vco[QW-1:0];
                r_b_fb     <= r_fb;
                r_b_p1     <= r_p1;
                r_b_p2     <= r_p2;
            end
            if (r_p2 > PD_W'(1)) begin
                r_p2 <= r_p2 - PD_W'(1);
            end else if (r_p1 > PD_W'(1)) begin
                r_p1 <= r_p1 - PD_W'(1);
                r_p2 <= r_p1 - PD_W'(1);
            end
        end
        if ((r_state == S_NEXT) && (r_fb != fb_last)) begin
            r_fb <= cfg.prefer_low_vco ? (r_fb + FB_W'(1)) : (r_fb - FB_W'(1));
        end
        if (out_load) begin
            r_o_found <= r_found;
            r_o_exact <= r_found && (r_b_khz == req_ext) && r_b_rz;
            r_o_khz   <= r_b_khz;
            r_o_vco   <= r_b_vco;
            r_o_fb    <= r_b_fb;
            r_o_p1    <= r_b_p1;
            r_o_p2    <= r_b_p2;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_o_found;
    assign o_exact        = r_o_exact;
    assign o_out_khz      = r_o_khz;
    assign o_vco_khz      = r_o_vco;
    assign o_feedback_div = pds_pkg::PDS_FB_OUT_W'(r_o_fb);
    assign o_post_div_one = pds_pkg::PDS_PD_OUT_W'(r_o_p1);
    assign o_post_div_two = pds_pkg::PDS_PD_OUT_W'(r_o_p2);

    `PDS_ASSERT_IMP(a_exact_needs_found, i_clk, i_rst_n,
        o_out_valid && o_exact, o_found, "exact flag without a found setting")
    `PDS_ASSERT_IMP(a_not_found_zero, i_clk, i_rst_n,
        o_out_valid && !o_found,
        (o_feedback_div == '0) && (o_post_div_one == '0) && (o_vco_khz == '0),
        "settings not zero when nothing was found")
    `PDS_ASSERT_IMP(a_div_done_wait, i_clk, i_rst_n,
        div_res.done, r_state == S_DWAIT, "divider finished outside its wait state")
    `PDS_ASSERT_IMP(a_pair_order, i_clk, i_rst_n,
        r_state == S_DSTART, (r_p2 != '0) && (r_p2 <= r_p1),
        "post divider two out of range")
    `PDS_ASSERT_NXT(a_eval_err_bound, i_clk, i_rst_n,
        r_state == S_EVAL, r_best_err <= QW'(ERROR_BOUND_KHZ),
        "best error above the bound")

endmodule
